// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/bei_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bei_pkg;

    localparam int BEI_MAX_RANK   = 4;
    localparam int BEI_DIM_BITS   = 16;
    localparam int BEI_INDEX_BITS = 32;

    localparam int CFG_W      = 64;
    localparam int CFG_ADDR_W = 2;
    localparam int RANK_W     = 3;
    localparam int IDX_W      = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IN_RANK  = 2'd0,
        CFG_IN_DIMS  = 2'd1,
        CFG_TGT_RANK = 2'd2,
        CFG_TGT_DIMS = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic              err;
        logic [RANK_W-1:0] rank;
    } t_shape_status;

endpackage

`default_nettype wire

// File: hw/rtl/bei_shape.sv
`timescale 1ns / 1ps
`default_nettype none

module bei_shape
    import bei_pkg::*;
#(
    parameter int MAX_RANK = BEI_MAX_RANK,
    parameter int DIM_BITS = BEI_DIM_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]              i_cfg_addr,
    input  logic [CFG_W-1:0]                   i_cfg_wdata,
    output logic [MAX_RANK-1:0][DIM_BITS-1:0]  o_div,
    output logic [MAX_RANK-1:0][DIM_BITS-1:0]  o_idim,
    output logic [MAX_RANK-1:0]                o_zero,
    output t_shape_status                      o_status,
    output logic [CFG_W-1:0]                   o_out_dims
);

    localparam int RK_W = $clog2(MAX_RANK + 1);

    logic [RANK_W-1:0] r_in_rank;
    logic [RANK_W-1:0] r_tgt_rank;
    logic [CFG_W-1:0]  r_in_dims;
    logic [CFG_W-1:0]  r_tgt_dims;

    logic [RK_W-1:0]   in_rk;
    logic [RK_W-1:0]   tgt_rk;
    logic [RK_W-1:0]   out_rk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rank  <= '0;
            r_in_dims  <= '0;
            r_tgt_rank <= '0;
            r_tgt_dims <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_IN_RANK:  r_in_rank  <= i_cfg_wdata[RANK_W-1:0];
                CFG_IN_DIMS:  r_in_dims  <= i_cfg_wdata;
                CFG_TGT_RANK: r_tgt_rank <= i_cfg_wdata[RANK_W-1:0];
                CFG_TGT_DIMS: r_tgt_dims <= i_cfg_wdata;
            endcase
        end
    end

    // saturate ranks to the supported maximum
    assign in_rk  = (32'(r_in_rank) > 32'(MAX_RANK))  ? RK_W'(MAX_RANK) : RK_W'(r_in_rank);
    assign tgt_rk = (32'(r_tgt_rank) > 32'(MAX_RANK)) ? RK_W'(MAX_RANK) : RK_W'(r_tgt_rank);
    assign out_rk = (in_rk > tgt_rk) ? in_rk : tgt_rk;

    always_comb begin
        logic [DIM_BITS-1:0] a;
        logic [DIM_BITS-1:0] b;
        logic [DIM_BITS-1:0] o;
        logic                mis;
        logic                act;
        logic                err;
        logic [CFG_W-1:0]    packed_dims;

        err         = 1'b0;
        packed_dims = '0;
        for (int p = 0; p < MAX_RANK; p++) begin
            a = '0;
            b = '0;
            // fields that would lie past the register read as zero
            if (p * DIM_BITS < CFG_W) begin
                a = DIM_BITS'(r_in_dims >> (p * DIM_BITS));
                b = DIM_BITS'(r_tgt_dims >> (p * DIM_BITS));
            end
            if (RK_W'(p) >= in_rk) begin
                a = DIM_BITS'(1);
            end
            if (RK_W'(p) >= tgt_rk) begin
                b = DIM_BITS'(1);
            end
            act = (RK_W'(p) < out_rk);
            mis = 1'b0;
            if (a == b || b == DIM_BITS'(1)) begin
                o = a;
            end else if (a == DIM_BITS'(1)) begin
                o = b;
            end else begin
                o   = '0;
                mis = 1'b1;
            end
            if (act && mis) begin
                err = 1'b1;
            end
            if (act && (p * DIM_BITS < CFG_W)) begin
                packed_dims = packed_dims | (CFG_W'(o) << (p * DIM_BITS));
            end
            o_idim[p] = a;
            o_div[p]  = act ? o : DIM_BITS'(1);
            o_zero[p] = act && (o == '0);
        end
        o_status.err  = err;
        o_status.rank = RANK_W'(out_rk);
        o_out_dims    = err ? '0 : packed_dims;
    end

endmodule

`default_nettype wire

// File: hw/rtl/bei_dim.sv
`timescale 1ns / 1ps
`default_nettype none

module bei_dim
    import bei_pkg::*;
#(
    parameter int DIM_BITS   = BEI_DIM_BITS,
    parameter int REST_BITS  = IDX_W,
    parameter int INDEX_BITS = BEI_INDEX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [DIM_BITS-1:0]   i_div,
    input  logic [DIM_BITS-1:0]   i_idim,
    input  logic                  i_zero,
    input  logic                  i_valid,
    input  logic [REST_BITS-1:0]  i_rest,
    input  logic [INDEX_BITS-1:0] i_src,
    input  logic [INDEX_BITS-1:0] i_stride,
    output logic                  o_valid,
    output logic [REST_BITS-1:0]  o_rest,
    output logic [INDEX_BITS-1:0] o_src,
    output logic [INDEX_BITS-1:0] o_stride
);

    // chain taps: entry 0 is the unit input, entry k+1 the register of divide stage k
    logic                  c_v      [REST_BITS+1];
    logic [DIM_BITS-1:0]   c_rem    [REST_BITS+1];
    logic [REST_BITS-1:0]  c_dq     [REST_BITS+1];
    logic [INDEX_BITS-1:0] c_src    [REST_BITS+1];
    logic [INDEX_BITS-1:0] c_stride [REST_BITS+1];

    logic                  r_v      [REST_BITS];
    logic [DIM_BITS-1:0]   r_rem    [REST_BITS];
    logic [REST_BITS-1:0]  r_dq     [REST_BITS];
    logic [INDEX_BITS-1:0] r_src    [REST_BITS];
    logic [INDEX_BITS-1:0] r_stride [REST_BITS];

    assign c_v[0]      = i_valid;
    assign c_rem[0]    = '0;
    assign c_dq[0]     = i_rest;
    assign c_src[0]    = i_src;
    assign c_stride[0] = i_stride;

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < REST_BITS; k++) begin : g_div
        logic [DIM_BITS:0] t;
        logic [DIM_BITS:0] diff;
        logic              ge;

        assign t    = {c_rem[k], c_dq[k][REST_BITS-1]};
        assign diff = t - {1'b0, i_div};
        assign ge   = (t >= {1'b0, i_div});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]    <= ge ? diff[DIM_BITS-1:0] : t[DIM_BITS-1:0];
                r_dq[k]     <= {c_dq[k][REST_BITS-2:0], ge};
                r_src[k]    <= c_src[k];
                r_stride[k] <= c_stride[k];
            end
        end

        assign c_v[k+1]      = r_v[k];
        assign c_rem[k+1]    = r_rem[k];
        assign c_dq[k+1]     = r_dq[k];
        assign c_src[k+1]    = r_src[k];
        assign c_stride[k+1] = r_stride[k];
    end

    // multiply stage: coordinate times stride, stride times input dimension
    logic [DIM_BITS-1:0]            coord;
    logic [DIM_BITS+INDEX_BITS-1:0] prod_full;
    logic [DIM_BITS+INDEX_BITS-1:0] stride_full;

    logic                  r_m_v;
    logic [REST_BITS-1:0]  r_m_rest;
    logic [INDEX_BITS-1:0] r_m_prod;
    logic [INDEX_BITS-1:0] r_m_src;
    logic [INDEX_BITS-1:0] r_m_stride;

    // broadcast input dimension and zero-sized output dimension give coordinate zero
    assign coord       = (i_zero || i_idim == DIM_BITS'(1)) ? '0 : c_rem[REST_BITS];
    assign prod_full   = coord * c_stride[REST_BITS];
    assign stride_full = c_stride[REST_BITS] * i_idim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (i_en) begin
            r_m_v <= c_v[REST_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_rest   <= i_zero ? '0 : c_dq[REST_BITS];
            r_m_prod   <= prod_full[INDEX_BITS-1:0];
            r_m_src    <= c_src[REST_BITS];
            r_m_stride <= stride_full[INDEX_BITS-1:0];
        end
    end

    // accumulate stage
    logic                  r_o_v;
    logic [REST_BITS-1:0]  r_o_rest;
    logic [INDEX_BITS-1:0] r_o_src;
    logic [INDEX_BITS-1:0] r_o_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (i_en) begin
            r_o_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_rest   <= r_m_rest;
            r_o_src    <= r_m_src + r_m_prod;
            r_o_stride <= r_m_stride;
        end
    end

    assign o_valid  = r_o_v;
    assign o_rest   = r_o_rest;
    assign o_src    = r_o_src;
    assign o_stride = r_o_stride;

endmodule

`default_nettype wire

// File: hw/rtl/bei_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

module bei_obuf
    import bei_pkg::*;
#(
    parameter int DATA_W = IDX_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_data
);

    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic [DATA_W-1:0] r_d0;
    logic [DATA_W-1:0] r_d1;
    logic              push;
    logic              pop;

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = (r_cnt != 2'd0) && !i_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // head entry drives the port; second entry takes the overflow
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_d0 <= (r_cnt == 2'd2) ? r_d1 : i_data;
        end else if (push && r_cnt == 2'd0) begin
            r_d0 <= i_data;
        end
        if (push && !pop && r_cnt == 2'd1) begin
            r_d1 <= i_data;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_d0;

endmodule

`default_nettype wire

// File: hw/rtl/broadcast_expand_index_map_top.sv
// channel   dir  handshake          payload
// config    in   i_cfg_we           i_cfg_addr, i_cfg_wdata
// item in   in   i_valid / o_stall  i_out_index
// result    out  o_valid / i_stall  o_src_index, o_shape_error, o_out_rank, o_out_dims
//
// One item per cycle while o_stall is low. Each item passes the input register, then in each
// dimension unit the one-bit-per-stage divider, a multiply stage and an accumulate stage.
// Reset (synchronous, active low) clears the shape registers to zero, all valid bits and
// the output buffer. A two-entry output buffer parts the sides: o_stall rises only when both
// entries hold results, and then the whole pipeline holds.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module broadcast_expand_index_map_top
    import bei_pkg::*;
#(
    parameter int MAX_RANK   = BEI_MAX_RANK,
    parameter int DIM_BITS   = BEI_DIM_BITS,
    parameter int INDEX_BITS = BEI_INDEX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [IDX_W-1:0]      i_out_index,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [IDX_W-1:0]      o_src_index,
    output logic                  o_shape_error,
    output logic [RANK_W-1:0]     o_out_rank,
    output logic [CFG_W-1:0]      o_out_dims
);

    localparam int REST_BITS = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;

    logic [MAX_RANK-1:0][DIM_BITS-1:0] w_div;
    logic [MAX_RANK-1:0][DIM_BITS-1:0] w_idim;
    logic [MAX_RANK-1:0]               w_zero;
    t_shape_status                     w_status;
    logic                              w_en;
    logic                              w_push;
    logic [IDX_W-1:0]                  w_res;

    bei_shape #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_shape (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_div       (w_div),
        .o_idim      (w_idim),
        .o_zero      (w_zero),
        .o_status    (w_status),
        .o_out_dims  (o_out_dims)
    );

    // input register
    logic                 r_in_v;
    logic [REST_BITS-1:0] r_in_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (w_en) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_rest <= i_out_index[REST_BITS-1:0];
        end
    end

    logic                  ch_v      [MAX_RANK+1];
    logic [INDEX_BITS-1:0] ch_src    [MAX_RANK+1];
    logic [REST_BITS-1:0]  ch_rest   [MAX_RANK];
    logic [INDEX_BITS-1:0] ch_stride [MAX_RANK];

    assign ch_v[0]      = r_in_v;
    assign ch_src[0]    = '0;
    assign ch_rest[0]   = r_in_rest;
    assign ch_stride[0] = INDEX_BITS'(1);

    // one unit per dimension, innermost first
    for (genvar d = 0; d < MAX_RANK; d++) begin : g_dim
        if (d < MAX_RANK - 1) begin : g_mid
            bei_dim #(
                .DIM_BITS   (DIM_BITS),
                .REST_BITS  (REST_BITS),
                .INDEX_BITS (INDEX_BITS)
            ) u_dim (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_en),
                .i_div    (w_div[d]),
                .i_idim   (w_idim[d]),
                .i_zero   (w_zero[d]),
                .i_valid  (ch_v[d]),
                .i_rest   (ch_rest[d]),
                .i_src    (ch_src[d]),
                .i_stride (ch_stride[d]),
                .o_valid  (ch_v[d+1]),
                .o_rest   (ch_rest[d+1]),
                .o_src    (ch_src[d+1]),
                .o_stride (ch_stride[d+1])
            );
        end else begin : g_last
            bei_dim #(
                .DIM_BITS   (DIM_BITS),
                .REST_BITS  (REST_BITS),
                .INDEX_BITS (INDEX_BITS)
            ) u_dim (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (w_en),
                .i_div    (w_div[d]),
                .i_idim   (w_idim[d]),
                .i_zero   (w_zero[d]),
                .i_valid  (ch_v[d]),
                .i_rest   (ch_rest[d]),
                .i_src    (ch_src[d]),
                .i_stride (ch_stride[d]),
                .o_valid  (ch_v[d+1]),
                .o_rest   (),
                .o_src    (ch_src[d+1]),
                .o_stride ()
            );
        end
    end

    // drop the index when the shapes do not broadcast
    assign w_res  = w_status.err ? '0 : IDX_W'(ch_src[MAX_RANK]);
    assign w_push = ch_v[MAX_RANK] && w_en;

    bei_obuf #(
        .DATA_W (IDX_W)
    ) u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ch_v[MAX_RANK]),
        .i_data  (w_res),
        .o_ready (w_en),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_src_index)
    );

    assign o_stall       = !w_en;
    assign o_shape_error = w_status.err;
    assign o_out_rank    = w_status.rank;

    `ASSERT_IMPLIES(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid)
    `ASSERT_NEXT(a_push_shown, i_clk, i_rst_n, w_push, o_valid)
    `ASSERT_NEXT(a_pipe_holds, i_clk, i_rst_n, !w_en, $stable(ch_v[MAX_RANK]))

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bei_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  src;
        logic              err;
        logic [RANK_W-1:0] rank;
        logic [CFG_W-1:0]  dims;
    } t_map_result;

    localparam int LONG_HOLD   = 600;
    localparam int RAND_ITEMS  = 1200;
    localparam int PRESS_PHASE = 6;

    // Tracks the shape registers and the source indexes still owed by the block.
    class expand_map_scoreboard;
        bit [RANK_W-1:0] in_rank, tgt_rank;
        bit [CFG_W-1:0]  in_dims, tgt_dims;
        t_map_result     pending_src[$];
        int              mismatches, checked, err_results;

        function void set_reg(t_cfg_reg sel, bit [CFG_W-1:0] val);
            case (sel)
                CFG_IN_RANK:  in_rank  = val[RANK_W-1:0];
                CFG_IN_DIMS:  in_dims  = val;
                CFG_TGT_RANK: tgt_rank = val[RANK_W-1:0];
                CFG_TGT_DIMS: tgt_dims = val;
                default: ;
            endcase
        endfunction

        function t_map_result broadcast_source(bit [IDX_W-1:0] out_idx);
            t_map_result r;
            int unsigned ir, tr, orank;
            bit [BEI_DIM_BITS-1:0] idim[BEI_MAX_RANK];
            bit [BEI_DIM_BITS-1:0] odim[BEI_MAX_RANK];
            bit [BEI_DIM_BITS-1:0] a, b, o;
            bit [63:0] rest, stride, src, c;
            bit bad;
            r = '0;
            bad = 1'b0;
            ir = (in_rank > BEI_MAX_RANK) ? BEI_MAX_RANK : in_rank;
            tr = (tgt_rank > BEI_MAX_RANK) ? BEI_MAX_RANK : tgt_rank;
            orank = (ir > tr) ? ir : tr;
            for (int p = 0; p < orank; p++) begin
                a = (p < ir) ? in_dims[p*BEI_DIM_BITS +: BEI_DIM_BITS] : 1;
                b = (p < tr) ? tgt_dims[p*BEI_DIM_BITS +: BEI_DIM_BITS] : 1;
                if (a == b || b == 1) begin
                    o = a;
                end else if (a == 1) begin
                    o = b;
                end else begin
                    bad = 1'b1;
                    o = 0;
                end
                idim[p] = a;
                odim[p] = o;
                r.dims[p*BEI_DIM_BITS +: BEI_DIM_BITS] = o;
            end
            rest = out_idx;
            stride = 1;
            src = 0;
            if (!bad) begin
                for (int p = 0; p < orank; p++) begin
                    // a zero-sized output dimension swallows the rest of the index
                    if (odim[p] == 0) begin
                        c = 0;
                        rest = 0;
                    end else begin
                        c = rest % odim[p];
                        rest = rest / odim[p];
                    end
                    if (idim[p] == 1)
                        c = 0;
                    src = (src + c * stride) & 64'hFFFF_FFFF;
                    stride = (stride * idim[p]) & 64'hFFFF_FFFF;
                end
            end else begin
                r.dims = '0;
            end
            r.src  = src[IDX_W-1:0];
            r.err  = bad;
            r.rank = orank[RANK_W-1:0];
            return r;
        endfunction

        function void note_index(bit [IDX_W-1:0] idx);
            pending_src.insert(pending_src.size(), broadcast_source(idx));
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 30)
                $display("mismatch: %s", msg);
        endtask

        task check_result(t_map_result got);
            t_map_result want;
            checked++;
            if (pending_src.size() == 0) begin
                report($sformatf("result with nothing pending, src_index %0h", got.src));
                return;
            end
            want = pending_src.pop_front();
            if (want.err)
                err_results++;
            if (got.src !== want.src)
                report($sformatf("src_index got %0h want %0h", got.src, want.src));
            if (got.err !== want.err)
                report($sformatf("shape_error got %b want %b", got.err, want.err));
            if (got.rank !== want.rank)
                report($sformatf("out_rank got %0d want %0d", got.rank, want.rank));
            if (got.dims !== want.dims)
                report($sformatf("out_dims got %h want %h", got.dims, want.dims));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]      i_cfg_wdata;
    logic                  i_valid;
    logic                  o_stall;
    logic [IDX_W-1:0]      i_out_index;
    logic                  o_valid;
    logic                  i_stall;
    logic [IDX_W-1:0]      o_src_index;
    logic                  o_shape_error;
    logic [RANK_W-1:0]     o_out_rank;
    logic [CFG_W-1:0]      o_out_dims;

    expand_map_scoreboard sb = new();
    int  items_sent;
    int  shape_settings;
    bit  hold_request;

    broadcast_expand_index_map_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_out_index   (i_out_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_src_index   (o_src_index),
        .o_shape_error (o_shape_error),
        .o_out_rank    (o_out_rank),
        .o_out_dims    (o_out_dims)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit [CFG_W-1:0] dims4(int d3, int d2, int d1, int d0);
        return {d3[15:0], d2[15:0], d1[15:0], d0[15:0]};
    endfunction

    task automatic write_shape(bit [RANK_W-1:0] ir, bit [CFG_W-1:0] id,
                               bit [RANK_W-1:0] tr, bit [CFG_W-1:0] td);
        t_cfg_reg        sel[4];
        bit [CFG_W-1:0]  val[4];
        sel = '{CFG_IN_RANK, CFG_IN_DIMS, CFG_TGT_RANK, CFG_TGT_DIMS};
        val = '{ir, id, tr, td};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= sel[i];
            i_cfg_wdata <= val[i];
            @(posedge i_clk);
            sb.set_reg(sel[i], val[i]);
        end
        i_cfg_we <= 1'b0;
        shape_settings++;
    endtask

    task automatic send_item(bit [IDX_W-1:0] idx);
        i_valid     <= 1'b1;
        i_out_index <= idx;
        do @(posedge i_clk); while (o_stall);
        sb.note_index(idx);
        items_sent++;
    endtask

    task automatic idle_gap(bit quiet);
        int unsigned r, n;
        if (quiet)
            return;
        r = $urandom_range(0, 99);
        if (r < 50)
            n = 0;
        else if (r < 85)
            n = $urandom_range(1, 3);
        else if (r < 97)
            n = $urandom_range(4, 20);
        else
            n = $urandom_range(50, 200);
        if (n > 0) begin
            i_valid     <= 1'b0;
            i_out_index <= $urandom;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // drop valid and wait for every owed result before touching the shape
    task automatic end_phase();
        i_valid <= 1'b0;
        while (sb.pending_src.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic rand_shape(output bit [RANK_W-1:0] ir, output bit [CFG_W-1:0] id,
                              output bit [RANK_W-1:0] tr, output bit [CFG_W-1:0] td,
                              output longint unsigned count);
        int unsigned irs, trs, orank, r;
        bit [15:0] a, b, o;
        ir = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        tr = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        id = {$urandom, $urandom};
        td = {$urandom, $urandom};
        count = 1;
        if ($urandom_range(0, 29) == 0) begin
            ir = 4;
            tr = 4;
            id = '1;
            td = ($urandom_range(0, 1) != 0) ? '1 : dims4(1, 1, 1, 1);
            count = 64'd65535 * 65535 * 65535 * 65535;
            return;
        end
        irs = (ir > BEI_MAX_RANK) ? BEI_MAX_RANK : ir;
        trs = (tr > BEI_MAX_RANK) ? BEI_MAX_RANK : tr;
        orank = (irs > trs) ? irs : trs;
        for (int p = 0; p < orank; p++) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                o = $urandom_range(1, 9);
            else if (r < 85)
                o = $urandom_range(10, 300);
            else if (r < 92)
                o = $urandom_range(1000, 65535);
            else if (r < 96)
                o = 0;
            else
                o = 1;
            if (p >= irs) begin
                a = 1;
                b = o;
            end else if (p >= trs) begin
                a = o;
                b = 1;
            end else if ($urandom_range(0, 1) != 0) begin
                a = o;
                b = ($urandom_range(0, 1) != 0) ? o : 16'd1;
            end else begin
                a = 1;
                b = o;
            end
            // now and then break the pair where both sides carry a dimension
            if (p < irs && p < trs && $urandom_range(0, 24) == 0) begin
                a = $urandom_range(2, 50);
                b = a + 1;
            end
            if (p < irs)
                id[p*BEI_DIM_BITS +: BEI_DIM_BITS] = a;
            if (p < trs)
                td[p*BEI_DIM_BITS +: BEI_DIM_BITS] = b;
            count = count * o;
        end
    endtask

    function automatic bit [IDX_W-1:0] pick_index(longint unsigned count);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        if (r < 25 || count == 0 || count > 64'hFFFF_FFFF)
            return $urandom;
        if (r < 30)
            return count + $urandom_range(0, 3);
        return {$urandom, $urandom} % count;
    endfunction

    // result side: check accepted results, draw stall stretches
    initial begin
        int unsigned stall_left, calm_left, r;
        bit hold_done;
        stall_left = 0;
        calm_left  = 0;
        hold_done  = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                sb.check_result({o_src_index, o_shape_error, o_out_rank, o_out_dims});
            if (hold_request && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && calm_left == 0) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    calm_left = $urandom_range(20, 200);
                end else begin
                    if (r < 80)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 95)
                        stall_left = $urandom_range(4, 20);
                    else
                        stall_left = $urandom_range(50, 200);
                    calm_left = $urandom_range(1, 6);
                end
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                if (calm_left > 0)
                    calm_left--;
            end
        end
    end

    initial begin
        bit [RANK_W-1:0]  ir, tr;
        bit [CFG_W-1:0]   id, td;
        longint unsigned  count;
        int               rand_items, phase, n;
        bit               quiet;
        rand_items     = 0;
        phase          = 0;
        items_sent     = 0;
        shape_settings = 0;
        hold_request   = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_out_index <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= CFG_IN_RANK;
        i_cfg_wdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // scalar shape straight out of reset
        send_item('0);
        send_item('1);
        end_phase();
        // input broadcast along two axes, garbage above both ranks
        write_shape(2, dims4(16'hBEEF, 16'h1234, 3, 1), 3, dims4(16'h7777, 2, 3, 4));
        send_item(0);
        send_item(5);
        send_item(23);
        send_item(24);
        send_item('1);
        end_phase();
        // incompatible pair
        write_shape(1, dims4(0, 0, 0, 3), 1, dims4(0, 0, 0, 4));
        send_item(7);
        send_item(0);
        end_phase();
        // zero-sized dimension paired with 1
        write_shape(2, dims4(0, 0, 0, 1), 2, dims4(0, 0, 1, 5));
        send_item(13);
        send_item('1);
        end_phase();
        // ranks above the limit, widest dimensions, wrapping strides
        write_shape(7, '1, 5, dims4(1, 1, 1, 1));
        send_item(0);
        send_item('1);
        send_item(32'h8000_0000);
        end_phase();
        // target adds an outer axis, both sides broadcast
        write_shape(3, dims4(0, 4, 1, 6), 4, dims4(2, 1, 5, 1));
        send_item(1);
        send_item(119);
        send_item(239);
        end_phase();
        // rank-zero target
        write_shape(4, dims4(5, 1, 3, 2), 0, '1);
        send_item(29);
        send_item(30);
        end_phase();
        // all dimensions zero
        write_shape(4, '0, 4, '0);
        send_item(32'h5A5A_5A5A);
        end_phase();

        while (rand_items < RAND_ITEMS) begin
            phase++;
            rand_shape(ir, id, tr, td, count);
            write_shape(ir, id, tr, td);
            if (phase == PRESS_PHASE) begin
                // back-to-back items against a long receiver hold
                hold_request = 1'b1;
                n = 400;
                quiet = 1'b1;
            end else begin
                n = $urandom_range(10, 70);
                quiet = ($urandom_range(0, 3) == 0);
            end
            for (int i = 0; i < n; i++) begin
                send_item(pick_index(count));
                idle_gap(quiet);
            end
            rand_items += n;
            end_phase();
        end

        repeat (150) @(posedge i_clk);
        if (sb.pending_src.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_src.size()));
        $display("summary: %0d items over %0d shape settings, %0d results checked",
                 items_sent, shape_settings, sb.checked);
        $display("summary: %0d shape-error results, one receiver hold of %0d cycles",
                 sb.err_results, LONG_HOLD);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: broadcast_expand_index_map_top.f
+incdir+hw/rtl
hw/rtl/bei_pkg.sv
hw/rtl/bei_shape.sv
hw/rtl/bei_dim.sv
hw/rtl/bei_obuf.sv
hw/rtl/broadcast_expand_index_map_top.sv
tb/tb_top.sv
